// ----- hw/rtl/spa_pkg.sv -----
`default_nettype none
package spa_pkg;

	localparam int unsigned CoefW = 32;
	localparam int unsigned ExpoW = 16;
	localparam int unsigned KindW = 2;

	typedef logic signed [CoefW-1:0] coef_t;
	typedef logic [ExpoW-1:0]        expo_t;

	typedef enum logic [KindW-1:0] {
		KIND_LOAD_A = 2'd0,
		KIND_LOAD_B = 2'd1,
		KIND_MERGE  = 2'd2,
		KIND_NONE   = 2'd3
	} kind_t;

	typedef enum logic {
		ST_IDLE,
		ST_MERGE
	} state_t;

	typedef struct packed {
		logic load_a;
		logic load_b;
		logic step;
		logic finish;
	} cmd_t;

	typedef struct packed {
		logic a_done;
		logic b_done;
		logic can_push;
	} status_t;

	typedef struct packed {
		coef_t coef;
		expo_t expo;
	} term_t;

endpackage
`default_nettype wire

// ----- hw/rtl/sparse_polynomial_add_top.sv -----
// Load beats (kind A or B) are taken while idle and produce no output.
// A merge beat walks both term stores one head comparison per cycle while the output
// is not stalled, kept or dropped; each kept term waits in a pending register until
// the next kept term or the finish command, then is registered onto the outputs.
// Reset (arst_n low, asynchronous) empties both lists, clears the overflow flag and mode.
`default_nettype none
module sparse_polynomial_add_top #(
	parameter int unsigned MAX_TERMS = 32
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           in_valid,
	output logic                in_stall,
	input  wire logic [1:0]     kind,
	input  wire spa_pkg::coef_t coefficient,
	input  wire spa_pkg::expo_t exponent,
	input  wire logic           cfg_we,
	input  wire logic           cfg_wdata,
	output logic                out_valid,
	input  wire logic           out_stall,
	output spa_pkg::coef_t      sum_coefficient,
	output spa_pkg::expo_t      sum_exponent,
	output logic                term_valid,
	output logic                last_term,
	output logic                overflowed
);
	import spa_pkg::*;

	cmd_t    cmd;
	status_t st;

	spa_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.kind     (kind),
		.st       (st),
		.cmd      (cmd)
	);

	spa_datapath #(
		.MAX_TERMS (MAX_TERMS)
	) u_datapath (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.st              (st),
		.cfg_we          (cfg_we),
		.cfg_wdata       (cfg_wdata),
		.coefficient     (coefficient),
		.exponent        (exponent),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.sum_coefficient (sum_coefficient),
		.sum_exponent    (sum_exponent),
		.term_valid      (term_valid),
		.last_term       (last_term),
		.overflowed      (overflowed)
	);

	a_cmd_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.load_a, cmd.load_b, cmd.step, cmd.finish}))
		else $error("more than one datapath command");

	a_finish_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |-> (st.a_done && st.b_done && st.can_push))
		else $error("finish before both lists are drained");

	a_finish_clears: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |=> !in_stall)
		else $error("merge did not return to idle");

	a_marker_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !term_valid) |-> last_term)
		else $error("empty marker not flagged last");

endmodule
`default_nettype wire

// ----- hw/rtl/spa_ctrl.sv -----
`default_nettype none
module spa_ctrl (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	output logic                  in_stall,
	input  wire logic [1:0]       kind,
	input  wire spa_pkg::status_t st,
	output spa_pkg::cmd_t         cmd
);
	import spa_pkg::*;

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_stall = 1'b1;
		case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					case (kind_t'(kind))
						KIND_LOAD_A: cmd.load_a = 1'b1;
						KIND_LOAD_B: cmd.load_b = 1'b1;
						KIND_MERGE:  state_d = ST_MERGE;
						default:     ;
					endcase
				end
			end
			ST_MERGE: begin
				if (st.can_push) begin
					if (st.a_done && st.b_done) begin
						cmd.finish = 1'b1;
						state_d    = ST_IDLE;
					end else begin
						cmd.step = 1'b1;
					end
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

endmodule
`default_nettype wire

// ----- hw/rtl/spa_datapath.sv -----
`default_nettype none
module spa_datapath #(
	parameter int unsigned MAX_TERMS = 32
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire spa_pkg::cmd_t       cmd,
	output spa_pkg::status_t         st,
	input  wire logic                cfg_we,
	input  wire logic                cfg_wdata,
	input  wire spa_pkg::coef_t      coefficient,
	input  wire spa_pkg::expo_t      exponent,
	output logic                     out_valid,
	input  wire logic                out_stall,
	output spa_pkg::coef_t           sum_coefficient,
	output spa_pkg::expo_t           sum_exponent,
	output logic                     term_valid,
	output logic                     last_term,
	output logic                     overflowed
);
	import spa_pkg::*;

	localparam int unsigned CW    = $clog2(MAX_TERMS + 1);
	localparam int unsigned IW    = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
	localparam int unsigned DEPTH = 2 ** IW;
	localparam logic [CW-1:0] FULL = CW'(MAX_TERMS);

	term_t mem_a [DEPTH];
	term_t mem_b [DEPTH];
	term_t rd_a_q;
	term_t rd_b_q;

	logic [CW-1:0] count_a_q;
	logic [CW-1:0] count_b_q;
	logic [CW-1:0] ia_q;
	logic [CW-1:0] ib_q;
	logic [CW-1:0] ia_d;
	logic [CW-1:0] ib_d;
	logic          ovf_q;
	logic          drop_q;

	term_t pend_q;
	logic  pend_valid_q;

	logic          take_a;
	logic          take_b;
	logic signed [CoefW:0] wide_sum;
	coef_t         sat_sum;
	term_t         new_term;
	logic          produce;
	logic          push;
	term_t         push_term;
	logic          push_valid;

	assign st.a_done   = (ia_q == count_a_q);
	assign st.b_done   = (ib_q == count_b_q);
	assign st.can_push = !out_valid || !out_stall;

	assign wide_sum = {rd_a_q.coef[CoefW-1], rd_a_q.coef}
		+ {rd_b_q.coef[CoefW-1], rd_b_q.coef};

	always_comb begin
		case (wide_sum[CoefW:CoefW-1])
			2'b01:   sat_sum = {1'b0, {(CoefW-1){1'b1}}};
			2'b10:   sat_sum = {1'b1, {(CoefW-1){1'b0}}};
			default: sat_sum = wide_sum[CoefW-1:0];
		endcase
	end

	always_comb begin
		take_a   = 1'b0;
		take_b   = 1'b0;
		new_term = rd_a_q;
		produce  = 1'b1;
		if (st.a_done) begin
			take_b   = 1'b1;
			new_term = rd_b_q;
		end else if (st.b_done) begin
			take_a = 1'b1;
		end else if (rd_a_q.expo > rd_b_q.expo) begin
			take_a = 1'b1;
		end else if (rd_a_q.expo < rd_b_q.expo) begin
			take_b   = 1'b1;
			new_term = rd_b_q;
		end else begin
			take_a        = 1'b1;
			take_b        = 1'b1;
			new_term.coef = sat_sum;
			produce       = !(drop_q && (sat_sum == '0));
		end
	end

	always_comb begin
		ia_d = ia_q;
		ib_d = ib_q;
		if (cmd.finish) begin
			ia_d = '0;
			ib_d = '0;
		end else if (cmd.step) begin
			if (take_a) ia_d = ia_q + 1'b1;
			if (take_b) ib_d = ib_q + 1'b1;
		end
	end

	assign push       = cmd.finish || (cmd.step && produce && pend_valid_q);
	assign push_valid = cmd.finish ? pend_valid_q : 1'b1;
	assign push_term  = (cmd.finish && !pend_valid_q) ? term_t'('0) : pend_q;

	always_ff @(posedge clk) begin
		if (cmd.load_a && (count_a_q != FULL)) begin
			mem_a[count_a_q[IW-1:0]] <= term_t'{coef: coefficient, expo: exponent};
		end
		if (cmd.load_b && (count_b_q != FULL)) begin
			mem_b[count_b_q[IW-1:0]] <= term_t'{coef: coefficient, expo: exponent};
		end
		rd_a_q <= mem_a[ia_d[IW-1:0]];
		rd_b_q <= mem_b[ib_d[IW-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_a_q    <= '0;
			count_b_q    <= '0;
			ia_q         <= '0;
			ib_q         <= '0;
			ovf_q        <= 1'b0;
			drop_q       <= 1'b0;
			pend_valid_q <= 1'b0;
			out_valid    <= 1'b0;
		end else begin
			ia_q <= ia_d;
			ib_q <= ib_d;
			if (cfg_we) begin
				drop_q <= cfg_wdata;
			end
			if (cmd.load_a) begin
				if (count_a_q != FULL) count_a_q <= count_a_q + 1'b1;
				else                   ovf_q     <= 1'b1;
			end
			if (cmd.load_b) begin
				if (count_b_q != FULL) count_b_q <= count_b_q + 1'b1;
				else                   ovf_q     <= 1'b1;
			end
			if (cmd.finish) begin
				count_a_q    <= '0;
				count_b_q    <= '0;
				ovf_q        <= 1'b0;
				pend_valid_q <= 1'b0;
			end else if (cmd.step && produce) begin
				pend_valid_q <= 1'b1;
			end
			if (push) begin
				out_valid <= 1'b1;
			end else if (!out_stall) begin
				out_valid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.step && produce) begin
			pend_q <= new_term;
		end
		if (push) begin
			sum_coefficient <= push_term.coef;
			sum_exponent    <= push_term.expo;
			term_valid      <= push_valid;
			last_term       <= cmd.finish;
			overflowed      <= ovf_q;
		end
	end

endmodule
`default_nettype wire
